[hdl/base62_pair_key_encoder_assert.svh]
// ----------------------------------------------------------------------------
// Base-62 pair key encoder assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BASE62_PAIR_KEY_ENCODER_ASSERT_SVH
`define BASE62_PAIR_KEY_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B62PK_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B62PK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/b62pk_pkg.sv]
// ----------------------------------------------------------------------------
// Base-62 pair key encoder package
// Types, constants and digit helpers shared by the encoder modules.
// ----------------------------------------------------------------------------
package b62pk_pkg;

  localparam int ValueWidth   = 64;
  localparam int NumDigits    = 11;
  localparam int MaxLowDigits = 10;
  localparam int BitsPerStage = 8;
  localparam int NumStages    = ValueWidth / BitsPerStage;
  localparam int CountWidth   = 4;

  localparam logic [5:0] DigitHalf  = 6'd31;
  localparam logic [5:0] TenDigit   = 6'd10;
  localparam logic [5:0] UpperEnd   = 6'd36;
  localparam logic [7:0] AsciiZero  = 8'd48;
  localparam logic [7:0] UpperBias  = 8'd55;
  localparam logic [7:0] LowerBias  = 8'd61;
  localparam logic [3:0] MaxLowCode = 4'd10;

  typedef logic [NumDigits-1:0][5:0] digit_vec_t;

  typedef struct packed {
    logic [ValueWidth-1:0] a_rem;
    logic [ValueWidth-1:0] b_rem;
    digit_vec_t            a_dig;
    digit_vec_t            b_dig;
  } conv_data_t;

  // Doubles a base-62 number and adds one bit; each carry depends only on
  // the old value of the digit below, so there is no ripple.
  function automatic digit_vec_t shift_in_bit(digit_vec_t d, logic b);
    digit_vec_t r;
    logic       c;
    logic [5:0] t;
    c = b;
    for (int i = 0; i < NumDigits; i++) begin
      t    = (d[i] >= DigitHalf) ? (d[i] - DigitHalf) : d[i];
      r[i] = {t[4:0], c};
      c    = (d[i] >= DigitHalf);
    end
    return r;
  endfunction

  function automatic logic [7:0] digit_char(logic [5:0] d);
    logic [7:0] r;
    if (d < TenDigit) begin
      r = AsciiZero + {2'b00, d};
    end else if (d < UpperEnd) begin
      r = UpperBias + {2'b00, d};
    end else begin
      r = LowerBias + {2'b00, d};
    end
    return r;
  endfunction

endpackage

[hdl/b62pk_conv_stage.sv]
// ----------------------------------------------------------------------------
// Base-62 conversion stage
// Shifts eight bits of each value into its base-62 digit vector.
// ----------------------------------------------------------------------------
module b62pk_conv_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  b62pk_pkg::conv_data_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output b62pk_pkg::conv_data_t  out_data
);

  b62pk_pkg::conv_data_t data_next;

  always_comb begin
    data_next       = in_data;
    data_next.a_rem = in_data.a_rem << b62pk_pkg::BitsPerStage;
    data_next.b_rem = in_data.b_rem << b62pk_pkg::BitsPerStage;
    for (int k = 0; k < b62pk_pkg::BitsPerStage; k++) begin
      data_next.a_dig = b62pk_pkg::shift_in_bit(data_next.a_dig,
                                                in_data.a_rem[b62pk_pkg::ValueWidth-1-k]);
      data_next.b_dig = b62pk_pkg::shift_in_bit(data_next.b_dig,
                                                in_data.b_rem[b62pk_pkg::ValueWidth-1-k]);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

[hdl/b62pk_serializer.sv]
// ----------------------------------------------------------------------------
// Base-62 key serialiser
// Checks the range and emits the key one character per transaction.
// ----------------------------------------------------------------------------
module b62pk_serializer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [3:0]             low_digit_count,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  b62pk_pkg::digit_vec_t  in_a_dig,
  input  b62pk_pkg::digit_vec_t  in_b_dig,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             key_char,
  output logic                   last_char,
  output logic                   range_error
);

  localparam int DigW = 6;
  localparam int NumD = b62pk_pkg::NumDigits;
  localparam int LowD = b62pk_pkg::MaxLowDigits;
  localparam int CntW = b62pk_pkg::CountWidth;

  logic                      busy;
  logic                      err;
  logic [CntW-1:0]           b_left;
  logic [CntW-1:0]           a_left;
  logic [NumD*DigW-1:0]      b_sh;
  logic [LowD*DigW-1:0]      a_sh;

  logic [CntW-1:0]           width_sat;
  logic [CntW-1:0]           nb;
  logic                      err_next;
  logic [NumD*DigW-1:0]      b_load;
  logic [LowD*DigW-1:0]      a_load;
  logic                      take;
  logic                      load;

  always_comb begin
    width_sat = (low_digit_count > b62pk_pkg::MaxLowCode) ? b62pk_pkg::MaxLowCode
                                                          : low_digit_count;
    err_next = (width_sat == '0);
    nb = CntW'(1);
    for (int i = 0; i < NumD; i++) begin
      if (in_b_dig[i] != '0) begin
        nb = CntW'(i + 1);
      end
      if ((CntW'(i) >= width_sat) && (in_a_dig[i] != '0)) begin
        err_next = 1'b1;
      end
    end
    b_load = in_b_dig << (7'(CntW'(NumD) - nb) * 7'(DigW));
    a_load = in_a_dig[LowD-1:0] << (7'(CntW'(LowD) - width_sat) * 7'(DigW));
  end

  assign take      = out_valid && out_ready;
  assign last_char = err || ((b_left == '0) && (a_left == CntW'(1)));
  assign in_ready  = !busy || (take && last_char);
  assign load      = in_valid && in_ready;
  assign out_valid = busy;
  assign range_error = err;

  always_comb begin
    if (err) begin
      key_char = '0;
    end else if (b_left != '0) begin
      key_char = b62pk_pkg::digit_char(b_sh[NumD*DigW-1 -: DigW]);
    end else begin
      key_char = b62pk_pkg::digit_char(a_sh[LowD*DigW-1 -: DigW]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (take && last_char) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      err    <= err_next;
      b_left <= nb;
      a_left <= width_sat;
      b_sh   <= b_load;
      a_sh   <= a_load;
    end else if (take) begin
      if (b_left != '0) begin
        b_left <= b_left - CntW'(1);
        b_sh   <= b_sh << DigW;
      end else begin
        a_left <= a_left - CntW'(1);
        a_sh   <= a_sh << DigW;
      end
    end
  end

endmodule

[hdl/base62_pair_key_encoder.sv]
// ----------------------------------------------------------------------------
// Base-62 pair key encoder
// Turns a pair of 64-bit values into an ASCII base-62 key.
// ----------------------------------------------------------------------------
// An input transaction carries first_value and second_value. The key leaves
// one character per output transaction: the minimal digits of second_value,
// then first_value padded with '0' to low_digit_count digits (11 to 15 act
// as 10). The final character has last_char set. If first_value does not fit
// or the count is zero, a single transaction with range_error and last_char
// set is sent instead.
// Eight conversion stages each take eight bits of both values; then the
// serialiser registers the digits and offers the first character. A key of
// up to 21 characters holds the output for one transaction per character,
// and following pairs wait in the conversion stages.
// Reset empties the pipeline and sets low_digit_count to 2. When the receiver
// stalls, every stage holds its data and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "base62_pair_key_encoder_assert.svh"

module base62_pair_key_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        low_digit_count_we,
  input  logic [3:0]  low_digit_count,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] first_value,
  input  logic [63:0] second_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  key_char,
  output logic        last_char,
  output logic        range_error
);

  localparam int NumSt = b62pk_pkg::NumStages;

  logic [3:0]            digit_count;
  b62pk_pkg::conv_data_t st_data [0:NumSt];
  logic                  st_valid [0:NumSt];
  logic                  st_ready [0:NumSt];
  logic                  out_take;
  logic                  char_legal;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= 4'd2;
    end else if (low_digit_count_we) begin
      digit_count <= low_digit_count;
    end
  end

  always_comb begin
    st_data[0].a_rem = first_value;
    st_data[0].b_rem = second_value;
    st_data[0].a_dig = '0;
    st_data[0].b_dig = '0;
  end

  assign st_valid[0] = in_valid;
  assign in_ready    = st_ready[0];

  for (genvar s = 0; s < NumSt; s++) begin : g_stage
    b62pk_conv_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (st_valid[s]),
      .in_ready  (st_ready[s]),
      .in_data   (st_data[s]),
      .out_valid (st_valid[s+1]),
      .out_ready (st_ready[s+1]),
      .out_data  (st_data[s+1])
    );
  end

  b62pk_serializer u_ser (
    .clk             (clk),
    .rst             (rst),
    .low_digit_count (digit_count),
    .in_valid        (st_valid[NumSt]),
    .in_ready        (st_ready[NumSt]),
    .in_a_dig        (st_data[NumSt].a_dig),
    .in_b_dig        (st_data[NumSt].b_dig),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .key_char        (key_char),
    .last_char       (last_char),
    .range_error     (range_error)
  );

  assign out_take   = out_valid && out_ready;
  assign char_legal = (key_char >= 8'd48 && key_char <= 8'd57) ||
                      (key_char >= 8'd65 && key_char <= 8'd90) ||
                      (key_char >= 8'd97 && key_char <= 8'd122);

  `B62PK_ASSERT_SAME(a_err_is_last, clk, rst, out_valid && range_error, last_char, "error not last")
  `B62PK_ASSERT_NEXT(a_key_no_gap, clk, rst, out_take && !last_char, out_valid, "gap inside a key")
  `B62PK_ASSERT_SAME(a_char_legal, clk, rst, out_valid && !range_error, char_legal, "bad character")

endmodule
